// ===== sv/tvfr_pkg.sv =====
// ---------------------------------------------------------------------------
// tvfr_pkg
// Shared types, codes and sizes for the tagged value frame receiver.
// ---------------------------------------------------------------------------
package tvfr_pkg;

    // Table size and frame geometry
    localparam int NUM_CHANNELS = 128;
    localparam int FRAME_LEN    = 8;
    localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(FRAME_LEN);

    // Marker bytes
    localparam logic [7:0] CH_START   = 8'h42;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_INT     = 8'h49;
    localparam logic [7:0] CH_FLOAT   = 8'h46;

    // Input operation codes
    localparam logic [1:0] OP_BYTE      = 2'd0;
    localparam logic [1:0] OP_READ_INT  = 2'd1;
    localparam logic [1:0] OP_READ_FLT  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_TAKEN     = 3'd0;
    localparam logic [2:0] ST_INT_STORE = 3'd1;
    localparam logic [2:0] ST_FLT_STORE = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;
    localparam logic [2:0] ST_READ      = 3'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [6:0] read_channel;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  frame_channel;
        logic [31:0] value_bits;
    } out_t;

    // Table write request from the frame logic
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } tbl_wr_t;

endpackage

// ===== sv/tvfr_ram.sv =====
// ---------------------------------------------------------------------------
// tvfr_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module tvfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold when not reading
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tvfr_table.sv =====
// ---------------------------------------------------------------------------
// tvfr_table
// One value table: RAM plus per-entry valid bits, so unwritten entries read
// as zero after reset, and a bypass for a write landing on the read address.
// ---------------------------------------------------------------------------
module tvfr_table
    import tvfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  tbl_wr_t           wr,
    output logic [31:0]       rd_data
);

    logic [(2**ADDR_W)-1:0] vld_reg;
    logic                   rd_vld_reg;
    logic                   byp_reg;
    logic [31:0]            byp_data_reg;
    logic [31:0]            ram_q;
    logic                   byp_next;

    tvfr_ram #(
        .WIDTH (32),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    assign byp_next = wr.en && (wr.addr == rd_addr);

    // Valid bits: clear on reset, set on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // Capture valid and bypass alongside the RAM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            byp_reg    <= 1'b0;
        end else if (rd_en) begin
            rd_vld_reg <= vld_reg[rd_addr];
            byp_reg    <= byp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_data_reg <= wr.data;
        end
    end

    // Resolve: fresh write wins, then stored entry, else reset value
    assign rd_data = byp_reg    ? byp_data_reg :
                     rd_vld_reg ? ram_q        : 32'd0;

endmodule

// ===== sv/tvfr_frame.sv =====
// ---------------------------------------------------------------------------
// tvfr_frame
// Frame assembly and item decode: hunts for the start byte, collects the
// frame, judges it on its last byte and forms the result word and writes.
// ---------------------------------------------------------------------------
module tvfr_frame
    import tvfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  in_t         item,
    input  logic [31:0] int_rd_data,
    input  logic [31:0] flt_rd_data,
    output out_t        result,
    output tbl_wr_t     int_wr,
    output tbl_wr_t     flt_wr
);

    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [7:0]       frame_bytes_reg [FRAME_LEN];
    logic             store_byte;

    logic [7:0]       chan;
    logic [7:0]       ftype;
    logic [31:0]      fval;
    logic             chan_ok;
    logic             read_ok;
    logic             last_byte;

    assign chan  = frame_bytes_reg[1];
    assign ftype = frame_bytes_reg[2];
    assign fval  = {frame_bytes_reg[6], frame_bytes_reg[5],
                    frame_bytes_reg[4], frame_bytes_reg[3]};

    assign chan_ok   = ({1'b0, chan} < 9'(NUM_CHANNELS));
    assign read_ok   = ({2'b00, item.read_channel} < 9'(NUM_CHANNELS));
    assign last_byte = (byte_count_reg == CNT_W'(FRAME_LEN - 1));

    // Decode the item
    always_comb begin
        result          = '0;
        int_wr          = '0;
        flt_wr          = '0;
        int_wr.addr     = chan[ADDR_W-1:0];
        flt_wr.addr     = chan[ADDR_W-1:0];
        int_wr.data     = fval;
        flt_wr.data     = fval;
        byte_count_next = byte_count_reg;
        store_byte      = 1'b0;
        case (item.op)
            OP_BYTE: begin
                result.status = ST_TAKEN;
                if (byte_count_reg == '0 && item.rx_byte != CH_START) begin
                    // skip while hunting
                end else if (!last_byte) begin
                    store_byte      = 1'b1;
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end else begin
                    byte_count_next      = '0;
                    result.frame_channel = chan;
                    result.value_bits    = fval;
                    if (item.rx_byte != CH_NEWLINE) begin
                        result.status = ST_MALFORMED;
                    end else if (chan_ok && ftype == CH_INT) begin
                        result.status = ST_INT_STORE;
                        int_wr.en     = advance;
                    end else if (chan_ok && ftype == CH_FLOAT) begin
                        result.status = ST_FLT_STORE;
                        flt_wr.en     = advance;
                    end else begin
                        result.status = ST_IGNORED;
                    end
                end
            end
            OP_READ_INT, OP_READ_FLT: begin
                result.status        = ST_READ;
                result.frame_channel = {1'b0, item.read_channel};
                if (read_ok) begin
                    result.value_bits = (item.op == OP_READ_INT) ? int_rd_data
                                                                  : flt_rd_data;
                end
            end
            default: begin
                result.status = ST_IGNORED;
            end
        endcase
    end

    // Advance the byte counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else if (advance) begin
            byte_count_reg <= byte_count_next;
        end
    end

    // Hold frame bytes
    always_ff @(posedge aclk) begin
        if (advance && store_byte) begin
            frame_bytes_reg[byte_count_reg] <= item.rx_byte;
        end
    end

endmodule

// ===== sv/tagged_value_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// tagged_value_frame_receiver
// Collects 8-byte tagged frames from a byte stream into integer and float
// tables and answers table reads.
// ---------------------------------------------------------------------------
//  channel | ports                    | word
//  --------+--------------------------+------------------------------------
//  input   | s_valid s_ready s_item   | op, rx_byte, read_channel
//  result  | m_valid m_ready m_item   | status, frame_channel, value_bits
//
//  One word in, one word out; a word per cycle sustained while the result
//  side takes each result. The table RAM read is issued on input accept,
//  decode runs in the item register stage, and the result sits in the
//  output register. Tables read as zero after reset via per-entry valid
//  bits; no clear pass. A stalled result holds the pipeline; a result
//  waiting blocks the next word only while the item register is full.
// ---------------------------------------------------------------------------
module tagged_value_frame_receiver
    import tvfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_item,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_item
);

    logic              s1_valid_reg;
    in_t               s1_item_reg;
    logic              m_valid_reg;
    out_t              m_item_reg;
    logic              s1_adv;
    logic              accept;
    logic [7:0]        rd_chan_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       int_rd_data;
    logic [31:0]       flt_rd_data;
    out_t              result;
    tbl_wr_t           int_wr;
    tbl_wr_t           flt_wr;

    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    assign rd_chan_ext = {1'b0, s_item.read_channel};
    assign rd_addr     = rd_chan_ext[ADDR_W-1:0];

    // Item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_item;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    tvfr_table u_int_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (int_wr),
        .rd_data (int_rd_data)
    );

    tvfr_table u_flt_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (flt_wr),
        .rd_data (flt_rd_data)
    );

    tvfr_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (s1_adv),
        .item        (s1_item_reg),
        .int_rd_data (int_rd_data),
        .flt_rd_data (flt_rd_data),
        .result      (result),
        .int_wr      (int_wr),
        .flt_wr      (flt_wr)
    );

endmodule

// ===== tb/sv/tb_tagged_value_frame_receiver.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tagged_value_frame_receiver
// Self-checking bench for the tagged value frame receiver. A driver pushes
// byte and read words from a queue, a predictor tracks frame assembly and
// both value tables, and a monitor compares every result word field by field.
// Three idling phases are run, with a long result stall and sender pauses.
// ---------------------------------------------------------------------------
module tb_tagged_value_frame_receiver;
    import tvfr_pkg::*;

    localparam logic [1:0] OP_SPARE       = 2'd3;
    localparam int         LONG_HOLD      = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         PHASE_WORDS    = 400;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    in_t  s_item  = '0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    out_t m_item;

    // Predictor state: frame assembly and the two value tables
    int          rx_count;
    logic [7:0]  rx_frame  [FRAME_LEN];
    logic [31:0] int_store [NUM_CHANNELS];
    logic [31:0] flt_store [NUM_CHANNELS];

    in_t  pending_words[$];
    out_t expected_replies[$];

    int words_queued  = 0;
    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    tagged_value_frame_receiver DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Work out the result word caused by one input word, updating state
    function automatic out_t predict_reply(in_t w);
        out_t        r;
        logic [7:0]  chan;
        logic [7:0]  kind;
        logic [31:0] val;
        r = '0;
        if (w.op == OP_BYTE) begin
            r.status = ST_TAKEN;
            if (rx_count != 0 || w.rx_byte == CH_START) begin
                rx_frame[rx_count] = w.rx_byte;
                rx_count++;
                if (rx_count == FRAME_LEN) begin
                    rx_count = 0;
                    chan = rx_frame[1];
                    kind = rx_frame[2];
                    val  = {rx_frame[6], rx_frame[5], rx_frame[4], rx_frame[3]};
                    r.frame_channel = chan;
                    r.value_bits    = val;
                    if (rx_frame[0] != CH_START || rx_frame[7] != CH_NEWLINE) begin
                        r.status = ST_MALFORMED;
                    end else if (chan < NUM_CHANNELS && kind == CH_INT) begin
                        int_store[chan] = val;
                        r.status = ST_INT_STORE;
                    end else if (chan < NUM_CHANNELS && kind == CH_FLOAT) begin
                        flt_store[chan] = val;
                        r.status = ST_FLT_STORE;
                    end else begin
                        r.status = ST_IGNORED;
                    end
                end
            end
        end else if (w.op == OP_READ_INT || w.op == OP_READ_FLT) begin
            r.status        = ST_READ;
            r.frame_channel = {1'b0, w.read_channel};
            if (w.read_channel < NUM_CHANNELS) begin
                r.value_bits = (w.op == OP_READ_INT) ? int_store[w.read_channel]
                                                     : flt_store[w.read_channel];
            end
        end else begin
            r.status = ST_IGNORED;
        end
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Queue one word with the given fields; callers often fill unused ones with random bits
    task automatic push_word(input logic [1:0] op, input logic [7:0] b,
                             input logic [6:0] ch);
        in_t w;
        w.op           = op;
        w.rx_byte      = b;
        w.read_channel = ch;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_read();
        logic [6:0] ch;
        ch = ($urandom_range(99) < 60) ? 7'($urandom_range(7)) : 7'($urandom_range(127));
        push_word($urandom_range(1) ? OP_READ_INT : OP_READ_FLT, 8'($urandom), ch);
    endtask

    // Queue a frame, with read words slipped in between its bytes now and then
    task automatic push_frame(input logic [7:0] chan, input logic [7:0] kind,
                              input logic [31:0] value, input logic [7:0] tail,
                              input int read_pct);
        logic [7:0] fb [FRAME_LEN];
        fb = '{CH_START, chan, kind, value[7:0], value[15:8], value[23:16],
               value[31:24], tail};
        for (int i = 0; i < FRAME_LEN; i++) begin
            push_word(OP_BYTE, fb[i], 7'($urandom));
            if ($urandom_range(99) < read_pct)
                push_read();
        end
    endtask

    function automatic logic [7:0] pick_channel();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'($urandom_range(7));
        else if (r < 92)
            return 8'($urandom_range(127));
        return 8'($urandom_range(255, 128));
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 32'h0;
        else if (r < 20)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Hold until the sender is empty and every expected word has arrived
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || expected_replies.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly well-formed frames with random content, mixed with broken ones, reads and noise
    task automatic run_phase(input int send_pct, input int recv_pct,
                             input bit long_hold);
        int         first;
        int         r;
        bit         paused;
        logic [7:0] tail;
        logic [7:0] kind;
        @(negedge aclk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (long_hold)
            hold_reqs++;
        first  = words_queued;
        paused = 1'b0;
        while (words_queued - first < PHASE_WORDS) begin
            r    = $urandom_range(99);
            kind = $urandom_range(1) ? CH_INT : CH_FLOAT;
            if (r < 55) begin
                push_frame(pick_channel(), kind, pick_value(), CH_NEWLINE, 10);
            end else if (r < 63) begin
                tail = 8'($urandom);
                if (tail == CH_NEWLINE)
                    tail = ~tail;
                push_frame(pick_channel(), kind, pick_value(), tail, 5);
            end else if (r < 70) begin
                push_frame(pick_channel(), 8'($urandom), pick_value(), CH_NEWLINE, 5);
            end else if (r < 85) begin
                push_read();
            end else if (r < 94) begin
                push_word(OP_BYTE, 8'($urandom), 7'($urandom));
            end else begin
                push_word(OP_SPARE, 8'($urandom), 7'($urandom));
            end
            // Pause the sender once per phase until the block has emptied
            if (!paused && words_queued - first >= PHASE_WORDS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // Input driver: predict on accept, then offer the next word or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item  <= '0;
        end else begin
            if (s_valid && s_ready)
                expected_replies.push_back(predict_reply(s_item));
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_item  <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result side ready: random idling, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served = hold_reqs;
            hold_left   = LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: compare each accepted word with the oldest expectation
    always @(posedge aclk) begin : result_monitor
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                report($sformatf("unexpected word status=%0d chan=0x%0h value=0x%0h",
                                 m_item.status, m_item.frame_channel,
                                 m_item.value_bits));
            end else begin
                want = expected_replies.pop_front();
                if (m_item.status !== want.status)
                    report($sformatf("status got %0d expected %0d",
                                     m_item.status, want.status));
                if (m_item.frame_channel !== want.frame_channel)
                    report($sformatf("frame_channel got 0x%0h expected 0x%0h",
                                     m_item.frame_channel, want.frame_channel));
                if (m_item.value_bits !== want.value_bits)
                    report($sformatf("value_bits got 0x%0h expected 0x%0h",
                                     m_item.value_bits, want.value_bits));
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("** tagged_value_frame_receiver: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        rx_count = 0;
        for (int i = 0; i < FRAME_LEN; i++)
            rx_frame[i] = 8'h00;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            int_store[i] = 32'h0;
            flt_store[i] = 32'h0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: cleared tables, spare op, skipped bytes, extreme frames
        @(negedge aclk);
        send_idle_pct = 13;
        recv_idle_pct = 69;
        push_word(OP_READ_INT, 8'h00, 7'd0);
        push_word(OP_READ_FLT, 8'hFF, 7'd127);
        push_word(OP_SPARE, 8'hFF, 7'h7F);
        push_word(OP_BYTE, 8'h00, 7'h7F);
        push_word(OP_BYTE, 8'hFF, 7'h00);
        push_frame(8'd127, CH_INT, 32'hFFFF_FFFF, CH_NEWLINE, 0);
        push_word(OP_READ_INT, 8'h00, 7'd127);
        push_frame(8'd0, CH_FLOAT, 32'h0000_0000, 8'h00, 0);
        push_word(OP_READ_FLT, 8'h00, 7'd0);
        wait_drained();

        run_phase(13, 69, 1'b0);
        run_phase(69, 13, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("** tagged_value_frame_receiver: PASSED **");
        else
            $display("** tagged_value_frame_receiver: FAILED **");
        $finish;
    end

endmodule
